### rtl/capwm_pkg.sv
// Package for the center-aligned PWM block: widths, reset values, register
// indexes, command codes and the result word layout. No dependencies.
package capwm_pkg;

  localparam int unsigned CHANNELS = 7;
  localparam int unsigned PEAK_W   = 16;
  localparam int unsigned DEAD_W   = 10;
  localparam int unsigned PHASE_W  = 17;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IN_W     = 24;
  localparam int unsigned OUT_W    = 24;

  localparam logic [PEAK_W-1:0]   PEAK_RST = 16'd4166;
  localparam logic [DEAD_W-1:0]   DEAD_RST = 10'd100;
  localparam logic [CHANNELS-1:0] EN_RST   = 7'h7F;
  localparam logic [CHANNELS-1:0] INV_RST  = 7'h08;

  localparam logic [IDX_W-1:0] REG_PEAK = 2'd0;
  localparam logic [IDX_W-1:0] REG_DEAD = 2'd1;
  localparam logic [IDX_W-1:0] REG_EN   = 2'd2;
  localparam logic [IDX_W-1:0] REG_INV  = 2'd3;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef logic [CHANNELS-1:0] chan_t;

  // packed from the lowest bit up: high_side, low_side, quarter, period_start, changed
  typedef struct packed {
    logic       changed;
    logic       period_start;
    logic [1:0] quarter;
    chan_t      low_side;
    chan_t      high_side;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

endpackage

### rtl/center_aligned_pwm_with_deadtime_top.sv
// Center-aligned complementary PWM with dead time, seven channels.
// Uses capwm_pkg. One module: tick/duty-write datapath plus a two-entry output skid.
//
//  channel | dir | fields
//  --------+-----+--------------------------------------------------------------
//  cfg     | in  | cfg_we_i, cfg_idx_i (0 peak, 1 dead time, 2 enable, 3 invert)
//  s       | in  | tuser: cmd; tdata: channel[2:0], duty_value[18:3]
//  m       | out | tdata: high_side[6:0], low_side[13:7], quarter[15:14],
//          |     |        period_start[16], changed[17]
//
// One word in, one word out; a word is taken every cycle while the skid stage is empty.
// The result shows on m in the cycle after acceptance when the output is free.
// Reset loads the register defaults and clears counter, duties and gate state.
// A stalled output holds one result and the skid stage takes one more;
// s_tready_o drops only while the skid stage is full.
module center_aligned_pwm_with_deadtime_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [capwm_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [capwm_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [capwm_pkg::IN_W-1:0]   s_tdata_i,   // channel, duty_value
  input  logic                         s_tuser_i,   // cmd
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [capwm_pkg::OUT_W-1:0]  m_tdata_o    // high, low, quarter, start, changed
);
  import capwm_pkg::*;

  logic [PEAK_W-1:0]   peak_q;
  logic [DEAD_W-1:0]   dead_q;
  chan_t               en_q, inv_q;
  logic [PHASE_W-1:0]  phase_q;
  logic [PEAK_W-1:0]   shadow_q [CHANNELS];
  logic [PEAK_W-1:0]   active_q [CHANNELS];
  logic [DEAD_W-1:0]   dc_q     [CHANNELS];
  logic [DEAD_W-1:0]   dc_d     [CHANNELS];
  chan_t               raw_q, del_q;
  chan_t               raw_d, del_d;
  logic [2*CHANNELS-1:0] last_q;

  logic                out_valid_q, skid_valid_q;
  result_t             out_q, skid_q;

  logic [CHAN_W-1:0]   in_chan;
  logic [PEAK_W-1:0]   in_duty;
  logic                is_write, acc, out_free;

  logic [PEAK_W-1:0]   pk;
  logic [PHASE_W-1:0]  pk2;
  logic [PHASE_W:0]    pk3;
  logic [PHASE_W-1:0]  ph_eff, ph_inc, ph_next, cnt, qph;
  logic [PHASE_W:0]    qph2;
  logic                start;
  logic [1:0]          quarter;
  chan_t               hi_t, lo_t;
  result_t             res;

  assign in_chan  = s_tdata_i[CHAN_W-1:0];
  assign in_duty  = s_tdata_i[CHAN_W +: PEAK_W];
  assign is_write = (s_tuser_i == CMD_WRITE);

  assign s_tready_o = !skid_valid_q;
  assign acc        = s_tvalid_i && s_tready_o;
  assign out_free   = !out_valid_q || m_tready_i;

  always_comb begin
    pk      = (peak_q < PEAK_W'(2)) ? PEAK_W'(2) : peak_q;
    pk2     = {pk, 1'b0};
    pk3     = {2'b00, pk} + {1'b0, pk2};
    ph_eff  = (phase_q >= pk2) ? '0 : phase_q;
    start   = (ph_eff == '0);
    cnt     = (ph_eff < {1'b0, pk}) ? ph_eff : pk2 - ph_eff;
    ph_inc  = ph_eff + PHASE_W'(1);
    ph_next = (ph_inc == pk2) ? '0 : ph_inc;
    qph     = is_write ? phase_q : ph_eff;
    qph2    = {qph, 1'b0};
    if (qph2 >= pk3) begin
      quarter = 2'd3;
    end else if (qph2 >= {1'b0, pk2}) begin
      quarter = 2'd2;
    end else if (qph2 >= {2'b00, pk}) begin
      quarter = 2'd1;
    end else begin
      quarter = 2'd0;
    end
  end

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      logic [PEAK_W-1:0] d;
      logic              on;
      logic [DEAD_W-1:0] cval;
      d = start ? shadow_q[i] : active_q[i];
      if (d == '0) begin
        on = 1'b0;
      end else if (d >= pk) begin
        on = 1'b1;
      end else begin
        on = (cnt < {1'b0, d});
      end
      raw_d[i] = on ^ inv_q[i];
      cval     = (raw_d[i] ^ raw_q[i]) ? dead_q : dc_q[i];
      del_d[i] = (cval == '0) ? raw_d[i] : del_q[i];
      dc_d[i]  = (cval == '0) ? '0 : cval - DEAD_W'(1);
    end
    hi_t = raw_d & del_d & en_q;
    lo_t = ~raw_d & ~del_d & en_q;
  end

  always_comb begin
    res.quarter = quarter;
    if (is_write) begin
      res.high_side    = raw_q & del_q & en_q;
      res.low_side     = ~raw_q & ~del_q & en_q;
      res.period_start = 1'b0;
      res.changed      = 1'b0;
    end else begin
      res.high_side    = hi_t;
      res.low_side     = lo_t;
      res.period_start = start;
      res.changed      = ({lo_t, hi_t} != last_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= PEAK_RST;
      dead_q <= DEAD_RST;
      en_q   <= EN_RST;
      inv_q  <= INV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PEAK: peak_q <= cfg_wdata_i[PEAK_W-1:0];
        REG_DEAD: dead_q <= cfg_wdata_i[DEAD_W-1:0];
        REG_EN:   en_q   <= cfg_wdata_i[CHANNELS-1:0];
        REG_INV:  inv_q  <= cfg_wdata_i[CHANNELS-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      raw_q   <= '0;
      del_q   <= '0;
      last_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        shadow_q[i] <= '0;
        active_q[i] <= '0;
        dc_q[i]     <= '0;
      end
    end else if (acc) begin
      if (is_write) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (in_chan == CHAN_W'(i)) begin
            shadow_q[i] <= in_duty;
          end
        end
      end else begin
        phase_q <= ph_next;
        raw_q   <= raw_d;
        del_q   <= del_d;
        last_q  <= {lo_t, hi_t};
        for (int i = 0; i < CHANNELS; i++) begin
          dc_q[i] <= dc_d[i];
          if (start) begin
            active_q[i] <= shadow_q[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= acc;
      end
    end else if (acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= res;
      end
    end else if (acc) begin
      skid_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {(OUT_W - RES_W)'(0), out_q};

endmodule

### rtl/capwm_checker.sv
// Port-level checker for the center-aligned PWM top, with its bind.
// Uses capwm_pkg for widths and command codes.
module capwm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_tvalid_i,
  input logic                         s_tready_o,
  input logic                         s_tuser_i,
  input logic                         m_tvalid_o,
  input logic                         m_tready_i,
  input logic [capwm_pkg::OUT_W-1:0]  m_tdata_o
);
  import capwm_pkg::*;

  logic s_acc, out_free;
  assign s_acc    = s_tvalid_i && s_tready_o;
  assign out_free = !m_tvalid_o || m_tready_i;

  a_no_shoot_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ((m_tdata_o[CHANNELS-1:0] & m_tdata_o[2*CHANNELS-1:CHANNELS]) == '0))
    else $error("high and low side on together");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o)
    else $error("input stalled with no result pending");

  a_word_delivered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && out_free) |=> m_tvalid_o)
    else $error("accepted word did not reach the output");

  a_write_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && out_free && s_tuser_i == CMD_WRITE) |=>
      (m_tdata_o[2*CHANNELS+2] == 1'b0 && m_tdata_o[2*CHANNELS+3] == 1'b0))
    else $error("duty write result carries start or changed flag");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o)))
    else $error("stalled output word changed");

endmodule

bind center_aligned_pwm_with_deadtime_top capwm_checker u_capwm_checker (.*);

### sim/tb_center_aligned_pwm_with_deadtime_top.sv
// Self-checking testbench for center_aligned_pwm_with_deadtime_top: a cycle model of the
// up-down counter, duty shadows and dead time predicts every result word under random idling.
// Depends on capwm_pkg and rtl/center_aligned_pwm_with_deadtime_top.sv.
module tb_center_aligned_pwm_with_deadtime_top;
  timeunit 1ns;
  timeprecision 1ps;

  import capwm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  class gate_scoreboard;
    logic [PEAK_W-1:0] peak_r;
    logic [DEAD_W-1:0] dead_r;
    chan_t             en_r;
    chan_t             inv_r;
    int unsigned       phase;
    logic [15:0]       shadow [CHANNELS];
    logic [15:0]       active [CHANNELS];
    logic [DEAD_W-1:0] dcnt [CHANNELS];
    chan_t             raw;
    chan_t             dly;
    logic [13:0]       last;
    result_t           gate_q [$];
    int unsigned       fails;
    int unsigned       seen;

    function new();
      peak_r = PEAK_RST;
      dead_r = DEAD_RST;
      en_r   = EN_RST;
      inv_r  = INV_RST;
      phase  = 0;
      shadow = '{default: '0};
      active = '{default: '0};
      dcnt   = '{default: '0};
      raw    = '0;
      dly    = '0;
      last   = '0;
      fails  = 0;
      seen   = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_PEAK: peak_r = v;
        REG_DEAD: dead_r = v[DEAD_W-1:0];
        REG_EN:   en_r   = v[CHANNELS-1:0];
        REG_INV:  inv_r  = v[CHANNELS-1:0];
        default: ;
      endcase
    endfunction

    function logic [1:0] quarter_in(int unsigned ph, int unsigned pk);
      int unsigned q;
      q = (2 * ph) / pk;
      return (q > 3) ? 2'd3 : q[1:0];
    endfunction

    function int unsigned pending();
      return gate_q.size();
    endfunction

    function void note_word(logic cmd, logic [CHAN_W-1:0] ch, logic [15:0] duty);
      result_t     r;
      int unsigned pk;
      int unsigned cnt;
      int unsigned d;
      chan_t       nraw;
      r = '0;
      pk = (peak_r < 2) ? 2 : peak_r;
      if (cmd == CMD_WRITE) begin
        if (ch < CHANNELS) shadow[ch] = duty;
        r.quarter = (phase >= 2 * pk) ? 2'd3 : quarter_in(phase, pk);
      end else begin
        if (phase >= 2 * pk) phase = 0;
        if (phase == 0) begin
          active = shadow;
          r.period_start = 1'b1;
        end
        cnt = (phase < pk) ? phase : 2 * pk - phase;
        r.quarter = quarter_in(phase, pk);
        nraw = '0;
        for (int i = 0; i < CHANNELS; i++) begin
          d = active[i];
          nraw[i] = (d == 0) ? 1'b0 : (d >= pk) ? 1'b1 : (cnt < d);
          if (inv_r[i]) nraw[i] = !nraw[i];
        end
        for (int i = 0; i < CHANNELS; i++) begin
          if (nraw[i] != raw[i]) dcnt[i] = dead_r;
          if (dcnt[i] == 0) dly[i] = nraw[i];
          else dcnt[i] = dcnt[i] - 1'b1;
        end
        raw = nraw;
        phase++;
        if (phase >= 2 * pk) phase = 0;
      end
      r.high_side = raw & dly & en_r;
      r.low_side  = ~raw & ~dly & en_r;
      if (cmd == CMD_TICK) begin
        r.changed = ({r.low_side, r.high_side} != last);
        last = {r.low_side, r.high_side};
      end
      gate_q.push_back(r);
    endfunction

    function void check_word(logic [OUT_W-1:0] w);
      result_t got;
      result_t exp_r;
      got = w[RES_W-1:0];
      seen++;
      if (gate_q.size() == 0) begin
        $error("result word %h with no word expected", w);
        fails++;
        return;
      end
      exp_r = gate_q.pop_front();
      if (got.high_side !== exp_r.high_side) begin
        $error("high_side: expected %h, got %h", exp_r.high_side, got.high_side);
        fails++;
      end
      if (got.low_side !== exp_r.low_side) begin
        $error("low_side: expected %h, got %h", exp_r.low_side, got.low_side);
        fails++;
      end
      if (got.quarter !== exp_r.quarter) begin
        $error("quarter: expected %0d, got %0d", exp_r.quarter, got.quarter);
        fails++;
      end
      if (got.period_start !== exp_r.period_start) begin
        $error("period_start: expected %b, got %b", exp_r.period_start, got.period_start);
        fails++;
      end
      if (got.changed !== exp_r.changed) begin
        $error("changed: expected %b, got %b", exp_r.changed, got.changed);
        fails++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              s_tvalid_i;
  logic              s_tready_o;
  logic [IN_W-1:0]   s_tdata_i;
  logic              s_tuser_i;
  logic              m_tvalid_o;
  logic              m_tready_i;
  logic [OUT_W-1:0]  m_tdata_o;

  gate_scoreboard sb = new();
  bit             calm;
  int unsigned    words_in;
  int unsigned    settings;
  int unsigned    quiet_cycles;

  center_aligned_pwm_with_deadtime_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stall, check every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) sb.check_word(m_tdata_o);
    m_tready_i <= (calm || !rst_ni) ? 1'b1 : ($urandom_range(99) >= 38);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", quiet_cycles);
      $display("[center_aligned_pwm_with_deadtime_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic cmd, input logic [CHAN_W-1:0] ch,
                           input logic [15:0] duty);
    while (!calm && $urandom_range(99) < 38) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= cmd;
    s_tdata_i  <= {{(IN_W - CHAN_W - 16){1'b0}}, duty, ch};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_word(cmd, ch, duty);
    words_in++;
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic write_regs(input logic [PEAK_W-1:0] pk, input logic [DEAD_W-1:0] dt,
                            input chan_t en, input chan_t inv);
    put_reg(REG_PEAK, pk);
    put_reg(REG_DEAD, CFG_W'(dt));
    put_reg(REG_EN, CFG_W'(en));
    put_reg(REG_INV, CFG_W'(inv));
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic send_random(input int unsigned pk);
    logic [CHAN_W-1:0] ch;
    logic [15:0]       duty;
    ch   = CHAN_W'($urandom_range(7));
    duty = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(99) < 70) begin
      send_word(CMD_TICK, ch, duty);
    end else begin
      case ($urandom_range(4))
        0: duty = '0;
        1: duty = 16'($urandom_range(pk));
        2: duty = 16'(pk);
        3: duty = 16'hFFFF;
        default: ;
      endcase
      ch = ($urandom_range(19) == 0) ? 3'd7 : CHAN_W'($urandom_range(CHANNELS - 1));
      send_word(CMD_WRITE, ch, duty);
    end
  endtask

  task automatic run_phase(input logic [PEAK_W-1:0] pk, input logic [DEAD_W-1:0] dt,
                           input chan_t en, input chan_t inv, input int unsigned n,
                           input bit hold_mid);
    int unsigned used;
    drain();
    write_regs(pk, dt, en, inv);
    used = (pk < 2) ? 2 : pk;
    for (int unsigned k = 0; k < n; k++) begin
      if (hold_mid && k == n / 2) drain();
      send_random(used);
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_PEAK;
    cfg_wdata_i <= '0;
    s_tvalid_i  <= 1'b0;
    s_tuser_i   <= CMD_TICK;
    s_tdata_i   <= '0;
    calm        = 1'b0;
    words_in    = 0;
    settings    = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: duty zero, full, above peak, inverted channel, bad channel
    write_regs(16'd4, 10'd1, 7'h7F, 7'h08);
    send_word(CMD_WRITE, 3'd0, 16'd0);
    send_word(CMD_WRITE, 3'd1, 16'd3);
    send_word(CMD_WRITE, 3'd2, 16'd4);
    send_word(CMD_WRITE, 3'd3, 16'hFFFF);
    send_word(CMD_WRITE, 3'd4, 16'd1);
    send_word(CMD_WRITE, 3'd5, 16'd2);
    send_word(CMD_WRITE, 3'd6, 16'd4);
    send_word(CMD_WRITE, 3'd7, 16'hABCD);
    repeat (12) send_word(CMD_TICK, CHAN_W'($urandom_range(7)),
                          16'($urandom_range(16'hFFFF)));
    // peak below two; phase is left past the shortened period
    drain();
    write_regs(16'd1, 10'd0, 7'h55, 7'h2A);
    send_word(CMD_WRITE, 3'd2, 16'd1);
    repeat (3) send_word(CMD_TICK, CHAN_W'($urandom_range(7)),
                         16'($urandom_range(16'hFFFF)));

    run_phase(16'd2, 10'd0, 7'h7F, 7'h00, 160, 1'b0);
    run_phase(16'hFFFF, 10'h3FF, 7'h00, 7'h7F, 120, 1'b0);
    run_phase(16'd0, 10'd2, CHANNELS'($urandom_range(127)),
              CHANNELS'($urandom_range(127)), 160, 1'b0);
    calm = 1'b1;
    run_phase(16'd12, 10'd3, 7'h7F, 7'h08, 200, 1'b0);
    calm = 1'b0;
    repeat (3) begin
      run_phase(PEAK_W'($urandom_range(40, 3)), DEAD_W'($urandom_range(10)),
                CHANNELS'($urandom_range(127)), CHANNELS'($urandom_range(127)),
                160, 1'b1);
    end
    run_phase(PEAK_RST, DEAD_RST, EN_RST, INV_RST, 160, 1'b0);
    drain();

    $display("Sent %0d words (ticks and duty writes) across %0d register settings;",
             words_in, settings);
    $display("compared %0d result words, %0d field mismatches.", sb.seen, sb.fails);
    if (sb.fails == 0) begin
      $display("[center_aligned_pwm_with_deadtime_top] OK");
    end else begin
      $display("[center_aligned_pwm_with_deadtime_top] ERROR");
    end
    $finish;
  end

endmodule

### center_aligned_pwm_with_deadtime_top.f
rtl/capwm_pkg.sv
rtl/center_aligned_pwm_with_deadtime_top.sv
rtl/capwm_checker.sv
sim/tb_center_aligned_pwm_with_deadtime_top.sv
